FILE: hw/rtl/acla_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// acla_pkg: shared definitions for the calibrated leaky-average ADC block
// Widths, register map, command and status codes, reset values and the
// saturation helpers used by the datapath.
// ============================================================================
package acla_pkg;

    // Field and datapath widths
    localparam int CODE_W = 10;
    localparam int LEN_W  = 16;
    localparam int GAIN_W = 16;
    localparam int OFF_W  = 24;
    localparam int VOLT_W = 27;
    localparam int SUM_W  = 48;
    localparam int ERR_W  = 32;
    localparam int PROD_W = CODE_W + GAIN_W;
    localparam int RAW_W  = 13;

    // APB port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEN_LOGIC  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEN_MOTOR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_LOGIC = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFF_LOGIC  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_MOTOR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFF_MOTOR  = 3'd5;

    // Register reset values
    localparam logic [LEN_W-1:0]         LEN_RST        = 16'd1;
    localparam logic [GAIN_W-1:0]        GAIN_LOGIC_RST = 16'd901;
    localparam logic signed [OFF_W-1:0]  OFF_LOGIC_RST  = -24'sd16044;
    localparam logic [GAIN_W-1:0]        GAIN_MOTOR_RST = 16'd1118;
    localparam logic signed [OFF_W-1:0]  OFF_MOTOR_RST  = 24'sd19156;

    // Commands
    localparam logic [1:0] CMD_RAW    = 2'd0;
    localparam logic [1:0] CMD_FILTER = 2'd1;
    localparam logic [1:0] CMD_SEED   = 2'd2;

    // Channel selects
    localparam logic [7:0] CHAN_LOGIC = 8'd1;
    localparam logic [7:0] CHAN_MOTOR = 8'd2;

    // Largest code plus one; the range check compares against it
    localparam logic [RAW_W-1:0] CODE_LIMIT = 13'd1024;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RX_ERR   = 2'd1,
        ST_DATA_ERR = 2'd2,
        ST_BAD_CHAN = 2'd3
    } status_t;

    // Divider handshake back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Saturation bounds expressed on the widened (SUM_W+1) datapath
    localparam logic signed [SUM_W:0] VOLT_MAX_W =
        {{(SUM_W-VOLT_W+2){1'b0}}, {(VOLT_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] VOLT_MIN_W =
        {{(SUM_W-VOLT_W+2){1'b1}}, {(VOLT_W-1){1'b0}}};
    localparam logic signed [SUM_W:0] SUM_MAX_W = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_MIN_W = {2'b11, {(SUM_W-1){1'b0}}};

    // Clamp a widened value into the voltage range.
    function automatic logic signed [VOLT_W-1:0] sat_volt(input logic signed [SUM_W:0] x);
        logic signed [SUM_W:0] y;
        y = x;
        if (x > VOLT_MAX_W) y = VOLT_MAX_W;
        if (x < VOLT_MIN_W) y = VOLT_MIN_W;
        return y[VOLT_W-1:0];
    endfunction

    // Clamp a widened value into the accumulator range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
        logic signed [SUM_W:0] y;
        y = x;
        if (x > SUM_MAX_W) y = SUM_MAX_W;
        if (x < SUM_MIN_W) y = SUM_MIN_W;
        return y[SUM_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/acla_div.sv
`timescale 1ns / 1ps
// ============================================================================
// acla_div: bit-serial signed divider
// Restoring division of a signed dividend by an unsigned, non-zero divisor,
// one quotient bit per cycle, truncating toward zero.
// ============================================================================
module acla_div #(
    parameter int DIVIDEND_W = acla_pkg::SUM_W,
    parameter int DIVISOR_W  = acla_pkg::LEN_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic signed [DIVIDEND_W-1:0]  quotient,
    output acla_pkg::div_status_t         status
);
    import acla_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_STEP = 3'b010,
        D_SIGN = 3'b100
    } dstate_t;

    dstate_t                 state_reg, state_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]    div_reg, div_next;
    logic                    neg_reg, neg_next;

    logic [DIVISOR_W:0]      trial;
    logic                    fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    // Work on the magnitude; the sign is restored at the end.
                    neg_next   = dividend[DIVIDEND_W-1];
                    quo_next   = dividend[DIVIDEND_W-1] ? -dividend : dividend;
                    rem_next   = '0;
                    div_next   = divisor;
                    cnt_next   = CNT_W'(DIVIDEND_W);
                    state_next = D_STEP;
                end
            end
            D_STEP:
            begin
                rem_next = fits ? DIVISOR_W'(trial - {1'b0, div_reg})
                                : trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = D_SIGN;
                end
            end
            D_SIGN:
            begin
                quo_next   = neg_reg ? -quo_reg : quo_reg;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign quotient    = $signed(quo_reg);
    assign status.busy = (state_reg != D_IDLE);
    assign status.done = done_reg;

    // The partial remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_STEP) |-> (rem_reg < div_reg))
        else $error("divider remainder reached the divisor");

endmodule

FILE: hw/rtl/adc_calibrated_leaky_average.sv
`timescale 1ns / 1ps
// ============================================================================
// adc_calibrated_leaky_average: calibrated battery ADC reader with averaging
// Extracts the ADC code from a two-byte transfer, converts it to volts per
// channel, and optionally runs or seeds a per-channel leaky-sum average.
// ============================================================================
// One item is handled at a time, and a finished result waits in an output
// register so that the next beat can be accepted before it is taken. An
// item that fails its checks goes straight to its result; a raw voltage
// takes a bit-serial code-by-gain multiply; a seed adds a serial multiply
// by the length; a filtered voltage adds two passes through the shared
// one-bit-per-cycle 48-bit divider. Configuration registers are written
// over the APB port; the user must write them only while the block is
// idle, as the block itself does not enforce this. A length of zero is
// treated as one.
module adc_calibrated_leaky_average (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic [7:0]                            channel,
    input  logic [7:0]                            byte_high,
    input  logic [7:0]                            byte_low,
    input  logic                                  transfer_ok,
    // Result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic signed [acla_pkg::VOLT_W-1:0]    voltage,
    output logic [acla_pkg::ERR_W-1:0]            error_total,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [acla_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [acla_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [acla_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import acla_pkg::*;

    localparam int CNT_W = $clog2(LEN_W + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_VOLT  = 8'b0000_0100,
        S_SEED  = 8'b0000_1000,
        S_DIV1  = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_REDIV = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // Configuration registers, one entry per channel
    logic [LEN_W-1:0]         len_reg  [2];
    logic [LEN_W-1:0]         len_next [2];
    logic [GAIN_W-1:0]        gain_reg [2];
    logic [GAIN_W-1:0]        gain_next[2];
    logic signed [OFF_W-1:0]  off_reg  [2];
    logic signed [OFF_W-1:0]  off_next [2];

    // Filter state
    logic signed [SUM_W-1:0]  sum_reg  [2];
    logic signed [SUM_W-1:0]  sum_next [2];
    logic [ERR_W-1:0]         err_count_reg, err_count_next;

    // Sequencer and datapath
    state_t                   state_reg, state_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic                     ch_reg, ch_next;
    logic [LEN_W-1:0]         n_reg, n_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]         mplier_reg, mplier_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [VOLT_W-1:0] volt_reg, volt_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [VOLT_W-1:0] res_volt_reg, res_volt_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [VOLT_W-1:0] out_volt_reg, out_volt_next;
    logic [ERR_W-1:0]         out_err_reg, out_err_next;

    // Divider interface
    logic                     div_start;
    logic signed [SUM_W-1:0]  div_quotient;
    div_status_t              div_status;

    // Wait for the second quotient of a filtered item
    logic                     res_pending_done;
    logic                     filt_wait_reg, filt_wait_next;

    // Combinational helpers
    logic                     in_accept;
    logic                     cfg_write;
    logic [REG_IDX_W-1:0]     cfg_idx;
    logic [RAW_W-1:0]         code_shift;
    logic                     ch_in;
    status_t                  status_raw;
    logic                     in_err;
    logic signed [SUM_W-1:0]  mac_addend;
    logic signed [SUM_W-1:0]  mac_sum;
    logic signed [SUM_W:0]    volt_wide;
    logic signed [VOLT_W-1:0] volt_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    // Code extraction and the item checks, in priority order
    assign code_shift = {byte_high[4:0], byte_low} >> 3;
    assign ch_in      = (channel == CHAN_MOTOR);

    always_comb
    begin
        priority if (!transfer_ok)
        begin
            status_raw = ST_RX_ERR;
        end
        else if (code_shift >= CODE_LIMIT)
        begin
            status_raw = ST_DATA_ERR;
        end
        else if (channel != CHAN_LOGIC && channel != CHAN_MOTOR)
        begin
            status_raw = ST_BAD_CHAN;
        end
        else
        begin
            status_raw = ST_OK;
        end
    end

    assign in_err = (status_raw != ST_OK);

    // Shift-and-add step shared by both serial multiplies
    assign mac_addend = (state_reg == S_SEED)
                      ? {{(SUM_W-VOLT_W){volt_reg[VOLT_W-1]}}, volt_reg}
                      : {{(SUM_W-GAIN_W){1'b0}}, gain_reg[ch_reg]};
    assign mac_sum    = {acc_reg[SUM_W-2:0], 1'b0}
                      + (mplier_reg[LEN_W-1] ? mac_addend : '0);

    // Offset correction of the code-by-gain product
    assign volt_wide = $signed({{(SUM_W+1-PROD_W){1'b0}}, acc_reg[PROD_W-1:0]})
                     + $signed({{(SUM_W+1-OFF_W){off_reg[ch_reg][OFF_W-1]}}, off_reg[ch_reg]});
    assign volt_sat  = sat_volt(volt_wide);

    // Register read-back
    always_comb
    begin
        unique case (cfg_idx)
            REG_LEN_LOGIC:  prdata = APB_DATA_W'(len_reg[0]);
            REG_LEN_MOTOR:  prdata = APB_DATA_W'(len_reg[1]);
            REG_GAIN_LOGIC: prdata = APB_DATA_W'(gain_reg[0]);
            REG_OFF_LOGIC:  prdata = APB_DATA_W'($unsigned(off_reg[0]));
            REG_GAIN_MOTOR: prdata = APB_DATA_W'(gain_reg[1]);
            REG_OFF_MOTOR:  prdata = APB_DATA_W'($unsigned(off_reg[1]));
            default:        prdata = '0;
        endcase
    end

    // Register writes
    always_comb
    begin
        len_next  = len_reg;
        gain_next = gain_reg;
        off_next  = off_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LEN_LOGIC:  len_next[0]  = pwdata[LEN_W-1:0];
                REG_LEN_MOTOR:  len_next[1]  = pwdata[LEN_W-1:0];
                REG_GAIN_LOGIC: gain_next[0] = pwdata[GAIN_W-1:0];
                REG_OFF_LOGIC:  off_next[0]  = $signed(pwdata[OFF_W-1:0]);
                REG_GAIN_MOTOR: gain_next[1] = pwdata[GAIN_W-1:0];
                REG_OFF_MOTOR:  off_next[1]  = $signed(pwdata[OFF_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Item sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        mplier_next     = mplier_reg;
        cnt_next        = cnt_reg;
        volt_next       = volt_reg;
        res_status_next = res_status_reg;
        res_volt_next   = res_volt_reg;
        sum_next        = sum_reg;
        err_count_next  = err_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_volt_next   = out_volt_reg;
        out_err_next    = out_err_reg;
        div_start       = 1'b0;

        // The output slot empties when its beat is taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    ch_next     = ch_in;
                    n_next      = (len_reg[ch_in] == '0) ? LEN_W'(1) : len_reg[ch_in];
                    acc_next    = '0;
                    mplier_next = {code_shift[CODE_W-1:0], {(LEN_W-CODE_W){1'b0}}};
                    cnt_next    = CNT_W'(CODE_W);
                    if (in_err)
                    begin
                        // A failed item counts once and returns a zero voltage;
                        // filter and seed commands report it as a receive error.
                        if (err_count_reg != '1)
                        begin
                            err_count_next = err_count_reg + 1'b1;
                        end
                        res_status_next = (command == CMD_FILTER || command == CMD_SEED)
                                        ? ST_RX_ERR : status_raw;
                        res_volt_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // Code times gain, one code bit per cycle, MSB first.
                acc_next    = mac_sum;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_VOLT;
                end
            end
            S_VOLT:
            begin
                volt_next = volt_sat;
                if (cmd_reg == CMD_SEED)
                begin
                    acc_next    = '0;
                    mplier_next = n_reg;
                    cnt_next    = CNT_W'(LEN_W);
                    state_next  = S_SEED;
                end
                else if (cmd_reg == CMD_FILTER)
                begin
                    res_status_next = ST_OK;
                    div_start       = 1'b1;
                    state_next      = S_DIV1;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_volt_next   = volt_sat;
                    state_next      = S_DONE;
                end
            end
            S_SEED:
            begin
                // Voltage times length; the product cannot leave the sum range.
                acc_next    = mac_sum;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    sum_next[ch_reg] = mac_sum;
                    res_status_next  = ST_OK;
                    res_volt_next    = '0;
                    state_next       = S_DONE;
                end
            end
            S_DIV1:
            begin
                // Leak: sum minus sum over N, which keeps its sign and cannot overflow.
                if (div_status.done)
                begin
                    acc_next   = sum_reg[ch_reg] - div_quotient;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next[ch_reg] = sat_sum($signed({acc_reg[SUM_W-1], acc_reg})
                                 + $signed({{(SUM_W+1-VOLT_W){volt_reg[VOLT_W-1]}}, volt_reg}));
                state_next       = S_REDIV;
            end
            S_REDIV:
            begin
                div_start  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_volt_next   = res_volt_reg;
                    out_err_next    = err_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The second quotient is the filtered output; it waits here in S_DONE
        // until the divider reports, then passes on as the result.
        if (state_reg == S_DONE && cmd_reg == CMD_FILTER && res_status_reg == ST_OK
            && !res_pending_done)
        begin
            state_next     = S_DONE;
            out_valid_next = out_valid_reg && !out_ready;
            out_status_next = out_status_reg;
            out_volt_next   = out_volt_reg;
            out_err_next    = out_err_reg;
            if (div_status.done)
            begin
                res_volt_next = sat_volt($signed({div_quotient[SUM_W-1], div_quotient}));
            end
        end
    end

    // The filtered result is ready once the second division has finished.
    always_comb
    begin
        filt_wait_next = filt_wait_reg;
        if (state_reg == S_REDIV)
        begin
            filt_wait_next = 1'b1;
        end
        else if (div_status.done && filt_wait_reg)
        begin
            filt_wait_next = 1'b0;
        end
    end

    assign res_pending_done = !filt_wait_reg;

    // Shared serial divider
    acla_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[ch_reg]),
        .divisor  (n_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // Control state, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            filt_wait_reg <= 1'b0;
            err_count_reg <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            len_reg[0]    <= LEN_RST;
            len_reg[1]    <= LEN_RST;
            gain_reg[0]   <= GAIN_LOGIC_RST;
            gain_reg[1]   <= GAIN_MOTOR_RST;
            off_reg[0]    <= OFF_LOGIC_RST;
            off_reg[1]    <= OFF_MOTOR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            filt_wait_reg <= filt_wait_next;
            err_count_reg <= err_count_next;
            sum_reg       <= sum_next;
            len_reg       <= len_next;
            gain_reg      <= gain_next;
            off_reg       <= off_next;
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ch_reg         <= ch_next;
        n_reg          <= n_next;
        acc_reg        <= acc_next;
        mplier_reg     <= mplier_next;
        cnt_reg        <= cnt_next;
        volt_reg       <= volt_next;
        res_status_reg <= res_status_next;
        res_volt_reg   <= res_volt_next;
        out_status_reg <= out_status_next;
        out_volt_reg   <= out_volt_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign voltage     = out_volt_reg;
    assign error_total = out_err_reg;

    // The divider is never restarted while it is still working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // A quotient only arrives while the sequencer is waiting for one.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV1 || state_reg == S_DONE))
        else $error("divider finished outside a division wait");

    // The error counter never goes down.
    a_err_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (err_count_reg >= $past(err_count_reg)))
        else $error("error counter decreased");

    // The error counter moves only on the cycle after an accepted beat.
    a_err_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(err_count_reg) |-> $past(in_accept))
        else $error("error counter changed without an accepted beat");

endmodule
